@@ rtl/core/wsc_pkg.sv @@
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types, constants and character classes for the word substring
// counter core.
// ----------------------------------------------------------------------------
`default_nettype none

package wsc_pkg;

    // default parameter values
    localparam int PATTERN_MAX_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    // fixed field widths
    localparam int CHAR_W        = 8;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int LEN_REG_W     = 5;
    localparam int OUT_W         = 32;
    localparam int PATTERN_CHARS = 16;
    localparam int PATTERN_IDX_W = 4;
    localparam int CHARS_PER_REG = 4;

    typedef logic [CHAR_W-1:0] char_t;
    typedef char_t [PATTERN_CHARS-1:0] pattern_t;

    // configuration register indices
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHARS_0_3   = 3'd0,
        CFG_CHARS_4_7   = 3'd1,
        CFG_CHARS_8_11  = 3'd2,
        CFG_CHARS_12_15 = 3'd3,
        CFG_LENGTH      = 3'd4
    } cfg_index_t;

    // separator characters
    localparam char_t CH_PERIOD = 8'h2E;
    localparam char_t CH_EXCL   = 8'h21;
    localparam char_t CH_QUEST  = 8'h3F;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_NUL    = 8'h00;

    // letter ranges
    localparam char_t CH_UPPER_A = 8'h41;
    localparam char_t CH_UPPER_Z = 8'h5A;
    localparam char_t CH_LOWER_A = 8'h61;
    localparam char_t CH_LOWER_Z = 8'h7A;

    function automatic logic is_separator(input char_t c);
        return (c == CH_PERIOD) || (c == CH_EXCL) || (c == CH_QUEST) ||
               (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_NUL);
    endfunction

    function automatic logic is_letter(input char_t c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/wsc_match.sv @@
// ----------------------------------------------------------------------------
// wsc_match
// Parallel compare of the most recent word characters against the
// active pattern characters.
// ----------------------------------------------------------------------------
`default_nettype none

module wsc_match #(
    parameter int PATTERN_MAX = wsc_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire wsc_pkg::char_t [PATTERN_MAX-1:0] window,   // newest at 0
    input  wire wsc_pkg::pattern_t                pattern,
    input  wire logic [LEN_W-1:0]                 act_len,
    output logic                                  hit
);

    logic [PATTERN_MAX-1:0] pos_ok;

    // window position j pairs with pattern character act_len-1-j
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pos
        logic [4:0] idx_full;
        assign idx_full = 5'(act_len) - 5'(j) - 5'd1;
        assign pos_ok[j] = (5'(j) >= 5'(act_len)) ||
            (window[j] == pattern[idx_full[wsc_pkg::PATTERN_IDX_W-1:0]]);
    end

    assign hit = &pos_ok;

endmodule

`default_nettype wire

@@ rtl/core/word_substring_counter_core.sv @@
// ----------------------------------------------------------------------------
// word_substring_counter_core
// Counts overlapping occurrences of a configured pattern that lie inside
// all-letter words of a byte stream; gives the total at end of text.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid, in_stall, character,       | in
//           | end_of_text                          |
//  result   | out_valid, out_stall, total_matches  | out
//  config   | cfg_valid, cfg_ready, cfg_index,     | in
//           | cfg_data                             |
//
//  One character per cycle while no end of text is held: an input register,
//  window compare and word bookkeeping, then the result register.
//  The result register only fills on end of text, so plain characters keep
//  flowing while a total waits; an end-of-text item holds in the input
//  register only while a previous total is still stalled.
//  Reset clears the word state, the total and both valid flags; pattern
//  registers reset to zero with length one. cfg_ready is always high.
`default_nettype none

module word_substring_counter_core #(
    parameter int PATTERN_MAX = wsc_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = wsc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [wsc_pkg::CHAR_W-1:0]      character,
    input  wire logic                            end_of_text,
    // result channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [wsc_pkg::OUT_W-1:0]            total_matches,
    // configuration channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [wsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [wsc_pkg::CFG_DATA_W-1:0] pat_reg [wsc_pkg::CHARS_PER_REG];
    logic [wsc_pkg::LEN_REG_W-1:0]  len_reg;

    // input stage
    logic                   stage_valid_reg;
    wsc_pkg::char_t         stage_char_reg;
    logic                   stage_eot_reg;

    // word state
    wsc_pkg::char_t [PATTERN_MAX-1:0] window_reg;
    logic [LEN_W-1:0]                 letters_reg;
    logic                             all_letters_reg;
    logic [COUNT_WIDTH-1:0]           matches_reg;
    logic [COUNT_WIDTH-1:0]           total_reg;

    // result register
    logic                             out_valid_reg;
    logic [wsc_pkg::OUT_W-1:0]        out_total_reg;

    logic                             advance;
    logic                             take_in;
    logic                             out_valid_next;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wsc_pkg::CHARS_PER_REG; i++)
            begin
                pat_reg[i] <= '0;
            end
            len_reg <= wsc_pkg::LEN_REG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wsc_pkg::CFG_CHARS_0_3:   pat_reg[0] <= cfg_data;
                wsc_pkg::CFG_CHARS_4_7:   pat_reg[1] <= cfg_data;
                wsc_pkg::CFG_CHARS_8_11:  pat_reg[2] <= cfg_data;
                wsc_pkg::CFG_CHARS_12_15: pat_reg[3] <= cfg_data;
                wsc_pkg::CFG_LENGTH:
                    len_reg <= cfg_data[wsc_pkg::LEN_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // pattern as characters and clamped length
    wsc_pkg::pattern_t pattern;
    logic [LEN_W-1:0]  act_len;

    always_comb
    begin
        for (int k = 0; k < wsc_pkg::PATTERN_CHARS; k++)
        begin
            pattern[k] = pat_reg[k / wsc_pkg::CHARS_PER_REG]
                                [(k % wsc_pkg::CHARS_PER_REG) * wsc_pkg::CHAR_W +: wsc_pkg::CHAR_W];
        end
        if (len_reg == '0)
        begin
            act_len = LEN_W'(1);
        end
        else if (len_reg > wsc_pkg::LEN_REG_W'(PATTERN_MAX))
        begin
            act_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            act_len = LEN_W'(len_reg);
        end
    end

    // handshake: stage moves on unless an end of text meets a stalled total
    assign advance  = stage_valid_reg &&
                      (!stage_eot_reg || !out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take_in || advance)
        begin
            stage_valid_reg <= take_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            stage_char_reg <= character;
            stage_eot_reg  <= end_of_text;
        end
    end

    // character classes of the staged item
    logic is_sep;
    logic word_char;

    assign is_sep    = wsc_pkg::is_separator(stage_char_reg) || stage_eot_reg;
    assign word_char = !is_sep;

    // window with the new character at the front
    wsc_pkg::char_t [PATTERN_MAX-1:0] window_next;

    always_comb
    begin
        window_next[0] = stage_char_reg;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // letter count, held at the window depth
    logic [LEN_W-1:0] letters_inc;

    assign letters_inc = (letters_reg == LEN_W'(PATTERN_MAX)) ?
                         letters_reg : letters_reg + LEN_W'(1);

    // pattern compare
    logic hit_raw;

    wsc_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .window  (window_next),
        .pattern (pattern),
        .act_len (act_len),
        .hit     (hit_raw)
    );

    logic hit;
    assign hit = hit_raw && (letters_inc >= act_len);

    // word close: saturating add of the word's matches
    logic [COUNT_WIDTH:0]   sum_wide;
    logic [COUNT_WIDTH-1:0] total_closed;
    logic                   word_counts;

    assign word_counts  = (letters_reg != '0) && all_letters_reg;
    assign sum_wide     = {1'b0, total_reg} + {1'b0, matches_reg};
    assign total_closed = !word_counts ? total_reg :
                          (sum_wide[COUNT_WIDTH] ? COUNT_MAX : sum_wide[COUNT_WIDTH-1:0]);

    // word state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            letters_reg     <= '0;
            all_letters_reg <= 1'b1;
            matches_reg     <= '0;
            total_reg       <= '0;
        end
        else if (advance)
        begin
            if (word_char)
            begin
                letters_reg <= letters_inc;
                if (!wsc_pkg::is_letter(stage_char_reg))
                begin
                    all_letters_reg <= 1'b0;
                end
                if (hit && (matches_reg != COUNT_MAX))
                begin
                    matches_reg <= matches_reg + COUNT_WIDTH'(1);
                end
            end
            else
            begin
                letters_reg     <= '0;
                all_letters_reg <= 1'b1;
                matches_reg     <= '0;
                total_reg       <= stage_eot_reg ? '0 : total_closed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && word_char)
        begin
            window_reg <= window_next;
        end
    end

    // result register
    logic [63:0] total_ext;
    assign total_ext = 64'(total_closed);

    always_comb
    begin
        priority if (advance && stage_eot_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_eot_reg)
        begin
            out_total_reg <= total_ext[wsc_pkg::OUT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign total_matches = out_total_reg;

    // checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid_reg && stage_eot_reg && out_valid_reg))
        else $error("input stalled without a blocked end of text");

    a_result_from_eot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && stage_eot_reg))
        else $error("result appeared without an end-of-text item");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stage_eot_reg) |=>
            (total_reg == '0 && letters_reg == '0 && matches_reg == '0))
        else $error("word state not cleared after end of text");

    a_letters_bound: assert property (@(posedge clk) disable iff (!rst_n)
        letters_reg <= LEN_W'(PATTERN_MAX))
        else $error("letter count beyond window depth");

endmodule

`default_nettype wire

@@ tb/sv/word_substring_counter_core_tb.sv @@
// ----------------------------------------------------------------------------
// word_substring_counter_core_tb
// Drives text through the core one character per transfer and checks each
// end-of-text total against a predictor that tracks the word state, the
// letter window and the running total. The pattern registers are reloaded
// between phases, with lengths at and beyond both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module word_substring_counter_core_tb;

    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 110;
    localparam int          SETTLE_CYCLES   = 6;
    localparam int          WATCHDOG_LIMIT  = 2000;
    localparam int          WINDOW          = wsc_pkg::PATTERN_CHARS;
    localparam longint unsigned TOTAL_CEIL  = 64'hFFFF_FFFF;
    localparam wsc_pkg::char_t CH_DIGIT_ONE = 8'h31;
    localparam wsc_pkg::char_t CH_HIGH_BYTE = 8'hFF;
    localparam wsc_pkg::char_t CASE_BIT     = 8'h20;
    localparam wsc_pkg::char_t SEP_CHARS [6] =
        '{wsc_pkg::CH_PERIOD, wsc_pkg::CH_EXCL, wsc_pkg::CH_QUEST,
          wsc_pkg::CH_SPACE, wsc_pkg::CH_COMMA, wsc_pkg::CH_NUL};
    // length register codes per phase: extremes, out-of-range and middling
    localparam logic [wsc_pkg::LEN_REG_W-1:0] LEN_CODES [PHASES] =
        '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd5, 5'd8, 5'd12};

    // ------------------------------------------------------------------------
    // occurrence tally: predicts the total given at each end of text
    // ------------------------------------------------------------------------
    class occurrence_tally;
        wsc_pkg::char_t     pattern_bytes [wsc_pkg::PATTERN_CHARS];
        logic [wsc_pkg::LEN_REG_W-1:0] length_code;
        wsc_pkg::char_t     word_tail [WINDOW];
        int unsigned        word_len;
        bit                 word_all_letters;
        longint unsigned    word_hits;
        longint unsigned    text_total;
        logic [wsc_pkg::OUT_W-1:0] expected_totals [$];
        int unsigned        errors;

        function new();
            foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
            foreach (word_tail[i]) word_tail[i] = '0;
            length_code = 5'd1;
            text_total  = 0;
            errors      = 0;
            close_word();
        endfunction

        function void write_reg(wsc_pkg::cfg_index_t idx,
                                logic [wsc_pkg::CFG_DATA_W-1:0] data);
            unique case (idx)
                wsc_pkg::CFG_CHARS_0_3, wsc_pkg::CFG_CHARS_4_7,
                wsc_pkg::CFG_CHARS_8_11, wsc_pkg::CFG_CHARS_12_15:
                begin
                    for (int b = 0; b < wsc_pkg::CHARS_PER_REG; b++)
                        pattern_bytes[int'(idx) * wsc_pkg::CHARS_PER_REG + b] =
                            data[8*b +: 8];
                end
                wsc_pkg::CFG_LENGTH:
                begin
                    length_code = data[wsc_pkg::LEN_REG_W-1:0];
                end
                default:
                begin
                end
            endcase
        endfunction

        // add the finished word's hits if it held letters only
        function void close_word();
            if (word_len > 0 && word_all_letters)
                text_total = (word_hits > TOTAL_CEIL - text_total) ?
                             TOTAL_CEIL : text_total + word_hits;
            word_len         = 0;
            word_all_letters = 1'b1;
            word_hits        = 0;
        endfunction

        // one accepted input transfer
        function void note_char(wsc_pkg::char_t c, logic eot);
            int unsigned span;
            bit          hit;
            if (eot)
            begin
                close_word();
                expected_totals.push_back(text_total[wsc_pkg::OUT_W-1:0]);
                text_total = 0;
                return;
            end
            if (c inside {wsc_pkg::CH_PERIOD, wsc_pkg::CH_EXCL, wsc_pkg::CH_QUEST,
                          wsc_pkg::CH_SPACE, wsc_pkg::CH_COMMA, wsc_pkg::CH_NUL})
            begin
                close_word();
                return;
            end
            for (int i = WINDOW - 1; i > 0; i--)
                word_tail[i] = word_tail[i-1];
            word_tail[0] = c;
            if (word_len < wsc_pkg::PATTERN_MAX_DEF)
                word_len++;
            if (!(c inside {[wsc_pkg::CH_UPPER_A:wsc_pkg::CH_UPPER_Z],
                            [wsc_pkg::CH_LOWER_A:wsc_pkg::CH_LOWER_Z]}))
                word_all_letters = 1'b0;
            // zero length acts as one, anything past the window as full width
            span = (length_code == 0) ? 1 :
                   (length_code > wsc_pkg::PATTERN_MAX_DEF) ? wsc_pkg::PATTERN_MAX_DEF
                                                            : length_code;
            if (word_len >= span)
            begin
                hit = 1'b1;
                for (int k = 0; k < span; k++)
                    if (word_tail[span - 1 - k] != pattern_bytes[k])
                        hit = 1'b0;
                if (hit && word_hits < TOTAL_CEIL)
                    word_hits++;
            end
        endfunction

        function void check_total(logic [wsc_pkg::OUT_W-1:0] actual);
            logic [wsc_pkg::OUT_W-1:0] want;
            if (expected_totals.size() == 0)
            begin
                $display("%0t: total_matches with nothing expected, expected none, actual %0d",
                         $time, actual);
                errors++;
                return;
            end
            want = expected_totals.pop_front();
            if (actual !== want)
            begin
                $display("%0t: total_matches mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_totals.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    wsc_pkg::char_t         character;
    logic                   end_of_text;
    logic                   out_valid;
    logic                   out_stall;
    logic [wsc_pkg::OUT_W-1:0]       total_matches;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [wsc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wsc_pkg::CFG_DATA_W-1:0]  cfg_data;

    occurrence_tally        tally;
    wsc_pkg::char_t         pat_bytes [wsc_pkg::PATTERN_CHARS];
    int                     pat_span;
    int                     phase_items;
    bit                     tx_quiet;
    bit                     rx_quiet;
    int                     stall_left;
    int                     stall_len;
    int                     idle_cycles;

    word_substring_counter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .character     (character),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .total_matches (total_matches),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one; none in quiet stretches
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic wsc_pkg::char_t rand_letter();
        if ($urandom_range(0, 1))
            return wsc_pkg::CH_LOWER_A + wsc_pkg::char_t'($urandom_range(0, 25));
        return wsc_pkg::CH_UPPER_A + wsc_pkg::char_t'($urandom_range(0, 25));
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall, check each accepted transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tally.check_total(total_matches);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            stall_len = pick_gap(rx_quiet);
            if (stall_len > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_len - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL word_substring_counter_core");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic push_char(input wsc_pkg::char_t c, input logic eot);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        character   <= c;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        tally.note_char(c, eot);
        phase_items++;
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input wsc_pkg::cfg_index_t idx,
                             input logic [wsc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tally.write_reg(idx, data);
    endtask

    // all pattern registers, the length with noise above its width, and the
    // unused indexes with random data
    task automatic load_pattern(input logic [wsc_pkg::LEN_REG_W-1:0] len_code);
        logic [wsc_pkg::CFG_DATA_W-1:0] data;
        for (int r = 0; r < wsc_pkg::PATTERN_CHARS / wsc_pkg::CHARS_PER_REG; r++)
        begin
            for (int b = 0; b < wsc_pkg::CHARS_PER_REG; b++)
                data[8*b +: 8] = pat_bytes[r * wsc_pkg::CHARS_PER_REG + b];
            write_reg(wsc_pkg::cfg_index_t'(r), data);
        end
        data = $urandom();
        data[wsc_pkg::LEN_REG_W-1:0] = len_code;
        write_reg(wsc_pkg::CFG_LENGTH, data);
        for (int r = int'(wsc_pkg::CFG_LENGTH) + 1; r < 2**wsc_pkg::CFG_INDEX_W; r++)
            write_reg(wsc_pkg::cfg_index_t'(r), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // wait for every total, then let in-flight characters drain
    task automatic settle();
        in_valid <= 1'b0;
        while (tally.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one text of words built mostly from the pattern's own characters
    task automatic send_text();
        wsc_pkg::char_t word_q [$];
        int    n_words;
        int    wlen;
        int    pos;
        int    r;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        n_words  = $urandom_range(1, 5);
        for (int w = 0; w < n_words; w++)
        begin
            word_q.delete();
            wlen = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 24);
            while (word_q.size() < wlen)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                begin
                    for (int k = 0; k < pat_span; k++)
                        word_q.push_back(pat_bytes[k]);
                end
                else if (r < 85)
                begin
                    word_q.push_back(pat_bytes[$urandom_range(0, pat_span - 1)]);
                end
                else
                begin
                    word_q.push_back(rand_letter());
                end
            end
            // noise byte anywhere in the word
            if (word_q.size() > 0 && $urandom_range(0, 9) == 0)
                word_q[$urandom_range(0, word_q.size() - 1)] =
                    wsc_pkg::char_t'($urandom_range(0, 255));
            // case flip
            if (word_q.size() > 0 && $urandom_range(0, 11) == 0)
            begin
                pos = $urandom_range(0, word_q.size() - 1);
                word_q[pos] = word_q[pos] ^ CASE_BIT;
            end
            foreach (word_q[i])
                push_char(word_q[i], 1'b0);
            if (w < n_words - 1 || $urandom_range(0, 1))
            begin
                push_char(SEP_CHARS[$urandom_range(0, 5)], 1'b0);
                if ($urandom_range(0, 9) == 0)
                    push_char(SEP_CHARS[$urandom_range(0, 5)], 1'b0);
            end
        end
        push_char(wsc_pkg::char_t'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        string          dtext;
        wsc_pkg::char_t dbytes [$];
        wsc_pkg::char_t l0;
        wsc_pkg::char_t l1;
        logic [wsc_pkg::LEN_REG_W-1:0] len_code;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        character   <= '0;
        end_of_text <= 1'b0;
        out_stall   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        stall_left  = 0;
        idle_cycles = 0;
        tx_quiet    = 1'b1;
        rx_quiet    = 1'b1;
        tally       = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset pattern is a lone zero byte, which can never match
        push_char(wsc_pkg::CH_LOWER_A, 1'b0);
        push_char(wsc_pkg::CH_LOWER_A, 1'b1);
        settle();

        // directed: overlap, non-letter word, case, empty word, zero byte,
        // high byte, end of text without a closing separator
        foreach (pat_bytes[i])
            pat_bytes[i] = wsc_pkg::char_t'($urandom_range(0, 255));
        pat_bytes[0] = wsc_pkg::CH_LOWER_A;
        pat_bytes[1] = wsc_pkg::CH_LOWER_A + 8'd1;
        load_pattern(5'd2);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        dtext = "abab ab,ab1!Ab?.";
        for (int i = 0; i < dtext.len(); i++)
            dbytes.push_back(dtext[i]);
        dbytes.push_back(wsc_pkg::CH_NUL);
        dbytes.push_back(wsc_pkg::CH_LOWER_A);
        dbytes.push_back(wsc_pkg::CH_LOWER_A + 8'd1);
        dbytes.push_back(CH_HIGH_BYTE);
        dbytes.push_back(wsc_pkg::CH_SPACE);
        dbytes.push_back(wsc_pkg::CH_LOWER_A);
        dbytes.push_back(wsc_pkg::CH_LOWER_A + 8'd1);
        foreach (dbytes[i])
            push_char(dbytes[i], 1'b0);
        push_char(CH_HIGH_BYTE, 1'b1);
        settle();

        // random phases, one pattern setting each
        for (int p = 0; p < PHASES; p++)
        begin
            len_code = LEN_CODES[p];
            pat_span = (len_code == 0) ? 1 :
                       (len_code > wsc_pkg::PATTERN_MAX_DEF) ? wsc_pkg::PATTERN_MAX_DEF
                                                             : len_code;
            l0 = rand_letter();
            l1 = rand_letter();
            for (int k = 0; k < wsc_pkg::PATTERN_CHARS; k++)
                pat_bytes[k] = (k < pat_span) ? ($urandom_range(0, 1) ? l0 : l1)
                                              : wsc_pkg::char_t'($urandom_range(0, 255));
            // a zero byte in the pattern, and a digit in another
            if (p == 3)
                pat_bytes[$urandom_range(0, pat_span - 1)] = wsc_pkg::CH_NUL;
            if (p == 6)
                pat_bytes[$urandom_range(0, pat_span - 1)] = CH_DIGIT_ONE;
            load_pattern(len_code);
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                send_text();
            settle();
        end

        if (tally.errors == 0)
            $display("PASS word_substring_counter_core");
        else
            $display("FAIL word_substring_counter_core");
        $finish;
    end

endmodule
